>>> rtl/core/tts_pkg.sv
// shared types and codes of the two level thread scheduler
`default_nettype none
package tts_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int TID_W    = 4;
    localparam int QUANT_W  = 8;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SETPRI = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HALTED  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREEMPT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWAP_LOW   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TERMINATED = 2'd3;

    localparam logic [APB_AW-1:0]  ADDR_QUANTUM  = 2'd0;
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIX
    } state_t;

endpackage
`default_nettype wire

>>> rtl/core/tts_ram.sv
// generic single write port ram with registered read
`default_nettype none
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/tts_queue.sv
// fifo of thread ids: ram plus head, tail and count
`default_nettype none
module tts_queue #(
    parameter int SLOTS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic [$clog2(SLOTS)-1:0] push_id,
    input  wire logic                     pop,
    output logic      [$clog2(SLOTS)-1:0] head_id,
    output logic      [$clog2(SLOTS):0]   count
);
    localparam int IDW = $clog2(SLOTS);
    localparam logic [IDW-1:0] LAST = IDW'(SLOTS - 1);
    localparam logic [IDW:0]   FULL = (IDW + 1)'(SLOTS);

    logic [IDW-1:0] head_reg, head_next;
    logic [IDW-1:0] tail_reg, tail_next;
    logic [IDW:0]   count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    // head entry is read every cycle, data shows in the cycle after
    tts_ram #(.WIDTH(IDW), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (tail_reg),
        .wdata (push_id),
        .raddr (head_reg),
        .rdata (head_id)
    );

    always_comb
    begin
        do_push    = push && (count_reg != FULL);
        // pop on an empty queue takes the id pushed in the same cycle
        do_pop     = pop && (count_reg != '0 || do_push);
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign count = count_reg;
endmodule
`default_nettype wire

>>> rtl/core/tts_cfg.sv
// apb register holding the quantum length
`default_nettype none
module tts_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tts_pkg::APB_AW-1:0]  paddr,
    input  wire logic [tts_pkg::APB_DW-1:0]  pwdata,
    output logic      [tts_pkg::APB_DW-1:0]  prdata,
    output logic                            pready,
    output logic      [tts_pkg::QUANT_W-1:0] quantum
);
    import tts_pkg::*;

    logic [QUANT_W-1:0] quantum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_QUANTUM)
        begin
            quantum_reg <= pwdata[QUANT_W-1:0];
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_QUANTUM) ? {{(APB_DW-QUANT_W){1'b0}}, quantum_reg} : '0;
    assign quantum = quantum_reg;
endmodule
`default_nettype wire

>>> rtl/core/two_level_thread_scheduler.sv
// top level of the two level priority round robin thread scheduler
// usage:
//   request channel: in_valid / in_stall carry cmd and priority_req
//   (create, exit, timer tick, set priority); a request is taken when
//   in_valid is high and in_stall is low
//   result channel: out_valid / out_stall carry one result per request
//   (status, new_tid, running_tid, running_priority, previous_tid,
//   switch_kind); the receiver holds out_stall to keep it
//   timing: a request is taken in idle, where the head and tick reads
//   start, then goes through exec for the read-modify-write; a create that
//   preempts a low thread also passes through fix, because the tick memory
//   has one write port and two slots get a fresh quantum; the result is
//   written into the output register at the end of exec
//   the next request is taken once the sequencer is idle and the output
//   register is empty or being drained in that cycle
//   reset: slot 0 runs at low priority with the reset quantum, both
//   queues empty; the first cycle after reset writes slot 0's quantum
//   and holds off requests; quantum_length sits at apb address 0; the user
//   writes it only while no request is in flight, unenforced by the block
`default_nettype none
module two_level_thread_scheduler #(
    parameter int THREAD_SLOTS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tts_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tts_pkg::APB_DW-1:0]   pwdata,
    output logic      [tts_pkg::APB_DW-1:0]   prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [tts_pkg::CMD_W-1:0]    cmd,
    input  wire logic                        priority_req,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [tts_pkg::STATUS_W-1:0] status,
    output logic      [tts_pkg::TID_W-1:0]    new_tid,
    output logic      [tts_pkg::TID_W-1:0]    running_tid,
    output logic                             running_priority,
    output logic      [tts_pkg::TID_W-1:0]    previous_tid,
    output logic      [tts_pkg::KIND_W-1:0]   switch_kind
);
    import tts_pkg::*;

    localparam int IDW = $clog2(THREAD_SLOTS);

    logic [QUANT_W-1:0] quantum;

    tts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .quantum (quantum)
    );

    state_t state_reg, state_next;

    // slot flags live in flops, one bit per slot
    logic [THREAD_SLOTS-1:0] use_reg, use_next;
    logic [THREAD_SLOTS-1:0] pri_reg, pri_next;
    logic [IDW-1:0]          run_reg, run_next;
    logic                    halt_reg, halt_next;
    logic [IDW-1:0]          fix_addr_reg, fix_addr_next;
    logic [CMD_W-1:0]        cmd_reg;
    logic                    req_reg;

    // slot 0 starts with the reset quantum: write it once after reset
    logic                    init_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [TID_W-1:0]        new_tid_reg, new_tid_next;
    logic [TID_W-1:0]        run_tid_reg, run_tid_next;
    logic                    run_pri_reg, run_pri_next;
    logic [TID_W-1:0]        prev_tid_reg, prev_tid_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;

    // tick memory port
    logic                    t_we;
    logic [IDW-1:0]          t_waddr;
    logic [QUANT_W-1:0]      t_wdata;
    logic [QUANT_W-1:0]      t_rdata;
    logic [QUANT_W-1:0]      t_dec;

    // queue controls
    logic                    hq_push, hq_pop, lq_push, lq_pop;
    logic [IDW-1:0]          hq_id, lq_id;
    logic [IDW-1:0]          hq_head, lq_head;
    logic [IDW:0]            hq_count, lq_count;

    // free slot search
    logic                    free_found;
    logic [IDW-1:0]          free_idx;

    logic                    accept;
    logic                    out_take;
    logic                    resched;
    logic                    push_prev;
    logic [IDW-1:0]          next_id;

    tts_ram #(.WIDTH(QUANT_W), .DEPTH(THREAD_SLOTS)) u_ticks (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (run_reg),
        .rdata (t_rdata)
    );

    tts_queue #(.SLOTS(THREAD_SLOTS)) u_high (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (hq_push),
        .push_id (hq_id),
        .pop     (hq_pop),
        .head_id (hq_head),
        .count   (hq_count)
    );

    tts_queue #(.SLOTS(THREAD_SLOTS)) u_low (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (lq_push),
        .push_id (lq_id),
        .pop     (lq_pop),
        .head_id (lq_head),
        .count   (lq_count)
    );

    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = init_reg || (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign t_dec    = t_rdata - 1'b1;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--)
        begin
            if (!use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDW'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        use_next       = use_reg;
        pri_next       = pri_reg;
        run_next       = run_reg;
        halt_next      = halt_reg;
        fix_addr_next  = fix_addr_reg;
        out_valid_next = out_valid_reg && !out_take;
        status_next    = status_reg;
        new_tid_next   = new_tid_reg;
        run_tid_next   = run_tid_reg;
        run_pri_next   = run_pri_reg;
        prev_tid_next  = prev_tid_reg;
        kind_next      = kind_reg;
        t_we           = 1'b0;
        t_waddr        = run_reg;
        t_wdata        = quantum;
        hq_push        = 1'b0;
        hq_pop         = 1'b0;
        lq_push        = 1'b0;
        lq_pop         = 1'b0;
        hq_id          = free_idx;
        lq_id          = free_idx;
        resched        = 1'b0;
        push_prev      = 1'b0;
        next_id        = run_reg;

        // first cycle after reset: quantum for slot 0
        if (init_reg)
        begin
            t_we    = 1'b1;
            t_waddr = '0;
            t_wdata = QUANTUM_RESET;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next  = ST_IDLE;
                status_next = STATUS_OK;
                new_tid_next = '0;
                kind_next   = KIND_NONE;
                if (halt_reg)
                begin
                    status_next = STATUS_HALTED;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (!free_found)
                            begin
                                status_next = STATUS_NO_SLOT;
                            end
                            else
                            begin
                                use_next[free_idx] = 1'b1;
                                pri_next[free_idx] = req_reg;
                                t_we         = 1'b1;
                                t_waddr      = free_idx;
                                new_tid_next = TID_W'({{TID_W{1'b0}}, free_idx});
                                if (req_reg)
                                begin
                                    hq_push = 1'b1;
                                end
                                else
                                begin
                                    lq_push = 1'b1;
                                end
                                // new high thread preempts a low one
                                if (!pri_reg[run_reg] && req_reg)
                                begin
                                    resched       = 1'b1;
                                    fix_addr_next = run_reg;
                                    state_next    = ST_FIX;
                                end
                            end
                        end
                        CMD_EXIT:
                        begin
                            use_next[run_reg] = 1'b0;
                            if (hq_count == '0 && lq_count == '0)
                            begin
                                halt_next   = 1'b1;
                                status_next = STATUS_HALTED;
                            end
                            else
                            begin
                                resched = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (!pri_reg[run_reg])
                            begin
                                t_we = 1'b1;
                                if (t_dec == '0)
                                begin
                                    resched = 1'b1;
                                end
                                else
                                begin
                                    t_wdata = t_dec;
                                end
                            end
                        end
                        CMD_SETPRI:
                        begin
                            pri_next[run_reg] = req_reg;
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase

                    if (resched)
                    begin
                        // requeue a live low thread behind the others
                        push_prev = use_next[run_reg] && !pri_next[run_reg];
                        if (push_prev)
                        begin
                            lq_push = 1'b1;
                            lq_id   = run_reg;
                        end
                        // empty queue pops the id pushed this cycle
                        if (hq_count != '0 || hq_push)
                        begin
                            hq_pop  = 1'b1;
                            next_id = (hq_count != '0) ? hq_head : hq_id;
                        end
                        else
                        begin
                            lq_pop  = 1'b1;
                            next_id = (lq_count != '0) ? lq_head : lq_id;
                        end
                        run_next = next_id;
                        if (next_id == run_reg)
                        begin
                            kind_next = KIND_NONE;
                        end
                        else if (pri_next[next_id] && !pri_next[run_reg])
                        begin
                            kind_next = KIND_PREEMPT;
                        end
                        else if (use_next[run_reg] && !pri_next[run_reg])
                        begin
                            kind_next = KIND_SWAP_LOW;
                        end
                        else if (!use_next[run_reg])
                        begin
                            kind_next = KIND_TERMINATED;
                        end
                        else
                        begin
                            kind_next = KIND_NONE;
                        end
                    end
                end
                out_valid_next = 1'b1;
                prev_tid_next  = TID_W'({{TID_W{1'b0}}, run_reg});
                run_tid_next   = TID_W'({{TID_W{1'b0}}, run_next});
                run_pri_next   = pri_next[run_next];
            end

            ST_FIX:
            begin
                // fresh quantum for the preempted thread
                t_we       = 1'b1;
                t_waddr    = fix_addr_reg;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            use_reg       <= {{(THREAD_SLOTS-1){1'b0}}, 1'b1};
            pri_reg       <= '0;
            run_reg       <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            use_reg       <= use_next;
            pri_reg       <= pri_next;
            run_reg       <= run_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b1;
        end
        else
        begin
            init_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fix_addr_reg <= fix_addr_next;
        status_reg   <= status_next;
        new_tid_reg  <= new_tid_next;
        run_tid_reg  <= run_tid_next;
        run_pri_reg  <= run_pri_next;
        prev_tid_reg <= prev_tid_next;
        kind_reg     <= kind_next;
        if (accept)
        begin
            cmd_reg <= cmd;
            req_reg <= priority_req;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign new_tid          = new_tid_reg;
    assign running_tid      = run_tid_reg;
    assign running_priority = run_pri_reg;
    assign previous_tid     = prev_tid_reg;
    assign switch_kind      = kind_reg;
endmodule
`default_nettype wire
